@@ design/bitp_pkg.sv @@
// Shared constants, codes and the result record for the boot-info
// framebuffer tag parser. No dependencies.
`default_nettype none

package bitp_pkg;

  // Byte offsets inside the block are kept to this many bits
  localparam int OFF_W = 27;

  localparam logic [31:0] MAGIC_VALUE = 32'h36d7_6289;
  localparam logic [31:0] MIN_TOTAL   = 32'd16;
  localparam logic [31:0] MAX_TOTAL   = 32'd67108864;  // 64 MiB

  localparam logic [63:0] LEGACY_TEXT_COLOR = 64'h0000_0000_000B_8000;
  localparam logic [63:0] LEGACY_TEXT_MONO  = 64'h0000_0000_000B_0000;
  localparam logic [31:0] MIN_WIDTH         = 32'd320;
  localparam logic [31:0] MIN_HEIGHT        = 32'd200;

  localparam logic [31:0] TAG_END         = 32'd0;
  localparam logic [31:0] TAG_FRAMEBUFFER = 32'd8;
  localparam logic [31:0] TAG_HDR_SIZE    = 32'd8;
  localparam logic [31:0] FB_MIN_SIZE     = 32'd32;
  localparam logic [31:0] FB_MASK_SIZE    = 32'd40;
  localparam logic [7:0]  FB_TYPE_RGB     = 8'd1;

  // Word positions relative to the start of a tag
  localparam logic [OFF_W-1:0] REL_TYPE    = 27'd0;
  localparam logic [OFF_W-1:0] REL_SIZE    = 27'd4;
  localparam logic [OFF_W-1:0] REL_ADDR_LO = 27'd8;
  localparam logic [OFF_W-1:0] REL_ADDR_HI = 27'd12;
  localparam logic [OFF_W-1:0] REL_PITCH   = 27'd16;
  localparam logic [OFF_W-1:0] REL_WIDTH   = 27'd20;
  localparam logic [OFF_W-1:0] REL_HEIGHT  = 27'd24;
  localparam logic [OFF_W-1:0] REL_FORMAT  = 27'd28;
  localparam logic [OFF_W-1:0] REL_RG_MASK = 27'd32;
  localparam logic [OFF_W-1:0] REL_B_MASK  = 27'd36;

  localparam logic [OFF_W-1:0] FIRST_TAG   = 27'd8;
  localparam logic [OFF_W-1:0] WORD_BYTES  = 27'd4;

  // Result status codes
  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_MAGIC = 2'd1;
  localparam logic [1:0] ST_SIZE  = 2'd2;
  localparam logic [1:0] ST_NOTAG = 2'd3;

  // Channel layout defaults
  localparam logic [7:0] RED_POS_DEF   = 8'd16;
  localparam logic [7:0] GREEN_POS_DEF = 8'd8;
  localparam logic [7:0] BLUE_POS_DEF  = 8'd0;
  localparam logic [3:0] CHAN_SIZE_DEF = 4'd8;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] fb_address;
    logic [31:0] line_pitch;
    logic [31:0] screen_width;
    logic [31:0] screen_height;
    logic [5:0]  pixel_bits;
    logic [7:0]  red_position;
    logic [3:0]  red_size;
    logic [7:0]  green_position;
    logic [3:0]  green_size;
    logic [7:0]  blue_position;
    logic [3:0]  blue_size;
  } result_t;

endpackage

`default_nettype wire

@@ design/bitp_ifs.sv @@
// Valid/ready channel interfaces for the boot-info framebuffer tag parser.
// Depends on nothing but plain logic types.
`default_nettype none

interface bitp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] info_word;
  logic        block_start;

  modport source (output valid, output info_word, output block_start, input ready);
  modport sink   (input valid, input info_word, input block_start, output ready);
endinterface

interface bitp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] fb_address;
  logic [31:0] line_pitch;
  logic [31:0] screen_width;
  logic [31:0] screen_height;
  logic [5:0]  pixel_bits;
  logic [7:0]  red_position;
  logic [3:0]  red_size;
  logic [7:0]  green_position;
  logic [3:0]  green_size;
  logic [7:0]  blue_position;
  logic [3:0]  blue_size;

  modport source (
    output valid, input ready,
    output status, output fb_address, output line_pitch, output screen_width,
    output screen_height, output pixel_bits,
    output red_position, output red_size, output green_position, output green_size,
    output blue_position, output blue_size
  );
  modport sink (
    input valid, output ready,
    input status, input fb_address, input line_pitch, input screen_width,
    input screen_height, input pixel_bits,
    input red_position, input red_size, input green_position, input green_size,
    input blue_position, input blue_size
  );
endinterface

`default_nettype wire

@@ design/bitp_fb_check.sv @@
// Acceptance check of a framebuffer tag at its format word.
// Depends on bitp_pkg for the limits and format codes.
`default_nettype none

module bitp_fb_check (
  input  wire logic [63:0] address,
  input  wire logic [31:0] pitch,
  input  wire logic [31:0] width,
  input  wire logic [31:0] height,
  input  wire logic [7:0]  bpp,
  input  wire logic [7:0]  ftype,
  output logic             fb_ok
);

  logic [33:0] need;
  logic        bpp_ok;
  logic        addr_ok;
  logic        size_ok;

  // Bytes needed per line: width times bytes per pixel (2, 3 or 4)
  always_comb begin
    need   = '0;
    bpp_ok = 1'b1;
    case (bpp)
      8'd15, 8'd16: need = {1'b0, width, 1'b0};
      8'd24:        need = {1'b0, width, 1'b0} + {2'b00, width};
      8'd32:        need = {width, 2'b00};
      default:      bpp_ok = 1'b0;
    endcase
  end

  assign addr_ok = (address != bitp_pkg::LEGACY_TEXT_COLOR) &&
                   (address != bitp_pkg::LEGACY_TEXT_MONO) && (address != 64'd0);
  assign size_ok = (width >= bitp_pkg::MIN_WIDTH) && (height >= bitp_pkg::MIN_HEIGHT);

  assign fb_ok = addr_ok && size_ok && (ftype == bitp_pkg::FB_TYPE_RGB) && bpp_ok &&
                 ({2'b00, pitch} >= need);

endmodule

`default_nettype wire

@@ design/boot_info_framebuffer_tag_parser.sv @@
// Top level of the boot-info framebuffer tag parser: input register, tag walk
// and result register. Depends on bitp_pkg, bitp_ifs and bitp_fb_check.
//
// Usage: boot information words stream in on in_ch, one 32-bit little-endian
// word per beat; block_start marks the total-size word of a new block. The
// loader magic is written on cfg_wr_en/cfg_wr_data before a block is sent.
// A block gives at most one result beat on out_ch: framebuffer found, wrong
// magic, bad total size, or no usable tag. Other words give no beat.
// A deciding word passes the input register, then the result register.
// Throughput: one word per cycle while out_ch is not stalled with a result
// held; each word passes the tag walk logic once between the two registers,
// and the widest path is the width times bytes-per-pixel compare.
// Reset leaves the block idle: words without block_start are dropped until a
// block starts. When the receiver stalls with a result held, one more word
// can sit in the input register; in_ch.ready then drops until out_ch drains.
`default_nettype none

module boot_info_framebuffer_tag_parser (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr_en,
  input  wire logic [31:0]  cfg_wr_data,
  bitp_in_if.sink           in_ch,
  bitp_out_if.source        out_ch
);

  localparam int OW = bitp_pkg::OFF_W;

  // Configuration
  logic [31:0] loader_magic_r;

  // Input register
  logic        s1_valid_r;
  logic [31:0] s1_word_r;
  logic        s1_start_r;
  logic        adv;

  // Walk state
  logic [OW-1:0] byte_offset_r, byte_offset_nxt;
  logic [OW-1:0] block_size_r,  block_size_nxt;
  logic [OW-1:0] tag_begin_r,   tag_begin_nxt;
  logic [31:0]   tag_type_r,    tag_type_nxt;
  logic [31:0]   tag_size_r,    tag_size_nxt;
  logic [63:0]   address_r,     address_nxt;
  logic [31:0]   pitch_r,       pitch_nxt;
  logic [31:0]   width_r,       width_nxt;
  logic [31:0]   height_r,      height_nxt;
  logic [7:0]    bpp_r,         bpp_nxt;
  logic [7:0]    ftype_r,       ftype_nxt;
  logic [7:0]    red_pos_r,     red_pos_nxt;
  logic [3:0]    red_size_r,    red_size_nxt;
  logic [7:0]    green_pos_r,   green_pos_nxt;
  logic [3:0]    green_size_r,  green_size_nxt;
  logic [7:0]    blue_pos_r,    blue_pos_nxt;
  logic [3:0]    blue_size_r,   blue_size_nxt;
  logic          parse_done_r,  parse_done_nxt;

  // Result
  logic               res_valid;
  logic [1:0]         res_status;
  bitp_pkg::result_t  res_data;
  logic               out_valid_r;
  bitp_pkg::result_t  out_data_r;

  // Walk helpers
  logic [OW-1:0] rel;
  logic [31:0]   skip_size;
  logic [34:0]   skip_pad;
  logic [34:0]   skip_nxt;
  logic          no_room;
  logic          overrun;
  logic          fb_ok;

  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loader_magic_r <= '0;
    end else if (cfg_wr_en) begin
      loader_magic_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_word_r  <= in_ch.info_word;
      s1_start_r <= in_ch.block_start;
    end
  end

  // Skip to the next 8-byte aligned tag; no room if its header passes the end
  assign rel       = byte_offset_r - tag_begin_r;
  assign skip_size = (rel == bitp_pkg::REL_SIZE) ? s1_word_r : tag_size_r;
  assign skip_pad  = ({3'b000, skip_size} + 35'd7) & ~35'd7;
  assign skip_nxt  = {{(35-OW){1'b0}}, tag_begin_r} + skip_pad;
  assign no_room   = (skip_nxt + 35'd8) > {{(35-OW){1'b0}}, block_size_r};
  assign overrun   = ({{(33-OW){1'b0}}, tag_begin_r} + {1'b0, s1_word_r}) >
                     {{(33-OW){1'b0}}, block_size_r};

  bitp_fb_check u_fb_check (
    .address (address_r),
    .pitch   (pitch_r),
    .width   (width_r),
    .height  (height_r),
    .bpp     (s1_word_r[7:0]),
    .ftype   (s1_word_r[15:8]),
    .fb_ok   (fb_ok)
  );

  // Tag walk: one word per pass
  always_comb begin
    byte_offset_nxt = byte_offset_r;
    block_size_nxt  = block_size_r;
    tag_begin_nxt   = tag_begin_r;
    tag_type_nxt    = tag_type_r;
    tag_size_nxt    = tag_size_r;
    address_nxt     = address_r;
    pitch_nxt       = pitch_r;
    width_nxt       = width_r;
    height_nxt      = height_r;
    bpp_nxt         = bpp_r;
    ftype_nxt       = ftype_r;
    red_pos_nxt     = red_pos_r;
    red_size_nxt    = red_size_r;
    green_pos_nxt   = green_pos_r;
    green_size_nxt  = green_size_r;
    blue_pos_nxt    = blue_pos_r;
    blue_size_nxt   = blue_size_r;
    parse_done_nxt  = parse_done_r;
    res_valid       = 1'b0;
    res_status      = bitp_pkg::ST_FOUND;

    if (s1_start_r) begin
      // New block: restart the walk and check magic and total size
      parse_done_nxt  = 1'b0;
      byte_offset_nxt = bitp_pkg::WORD_BYTES;
      tag_begin_nxt   = bitp_pkg::FIRST_TAG;
      tag_type_nxt    = '0;
      tag_size_nxt    = '0;
      address_nxt     = '0;
      pitch_nxt       = '0;
      width_nxt       = '0;
      height_nxt      = '0;
      bpp_nxt         = '0;
      ftype_nxt       = '0;
      red_pos_nxt     = bitp_pkg::RED_POS_DEF;
      red_size_nxt    = bitp_pkg::CHAN_SIZE_DEF;
      green_pos_nxt   = bitp_pkg::GREEN_POS_DEF;
      green_size_nxt  = bitp_pkg::CHAN_SIZE_DEF;
      blue_pos_nxt    = bitp_pkg::BLUE_POS_DEF;
      blue_size_nxt   = bitp_pkg::CHAN_SIZE_DEF;
      block_size_nxt  = '0;
      if (loader_magic_r != bitp_pkg::MAGIC_VALUE) begin
        res_valid  = 1'b1;
        res_status = bitp_pkg::ST_MAGIC;
      end else if (s1_word_r < bitp_pkg::MIN_TOTAL || s1_word_r > bitp_pkg::MAX_TOTAL) begin
        res_valid  = 1'b1;
        res_status = bitp_pkg::ST_SIZE;
      end else begin
        block_size_nxt = s1_word_r[OW-1:0];
      end
    end else if (!parse_done_r) begin
      byte_offset_nxt = byte_offset_r + bitp_pkg::WORD_BYTES;
      if (byte_offset_r >= tag_begin_r) begin
        case (rel)
          bitp_pkg::REL_TYPE: tag_type_nxt = s1_word_r;
          bitp_pkg::REL_SIZE: begin
            tag_size_nxt = s1_word_r;
            if (s1_word_r < bitp_pkg::TAG_HDR_SIZE || overrun ||
                tag_type_r == bitp_pkg::TAG_END) begin
              res_valid  = 1'b1;
              res_status = bitp_pkg::ST_NOTAG;
            end else if (!(tag_type_r == bitp_pkg::TAG_FRAMEBUFFER &&
                           s1_word_r >= bitp_pkg::FB_MIN_SIZE)) begin
              tag_begin_nxt = skip_nxt[OW-1:0];
              if (no_room) begin
                res_valid  = 1'b1;
                res_status = bitp_pkg::ST_NOTAG;
              end
            end
          end
          bitp_pkg::REL_ADDR_LO: address_nxt[31:0]  = s1_word_r;
          bitp_pkg::REL_ADDR_HI: address_nxt[63:32] = s1_word_r;
          bitp_pkg::REL_PITCH:   pitch_nxt  = s1_word_r;
          bitp_pkg::REL_WIDTH:   width_nxt  = s1_word_r;
          bitp_pkg::REL_HEIGHT:  height_nxt = s1_word_r;
          bitp_pkg::REL_FORMAT: begin
            bpp_nxt   = s1_word_r[7:0];
            ftype_nxt = s1_word_r[15:8];
            if (!fb_ok) begin
              tag_begin_nxt = skip_nxt[OW-1:0];
              if (no_room) begin
                res_valid  = 1'b1;
                res_status = bitp_pkg::ST_NOTAG;
              end
            end else if (tag_size_r < bitp_pkg::FB_MASK_SIZE) begin
              res_valid  = 1'b1;
              res_status = bitp_pkg::ST_FOUND;
            end
          end
          bitp_pkg::REL_RG_MASK: begin
            if (s1_word_r[15:8] >= 8'd1 && s1_word_r[15:8] <= 8'd8) begin
              red_pos_nxt  = s1_word_r[7:0];
              red_size_nxt = s1_word_r[11:8];
            end
            if (s1_word_r[31:24] >= 8'd1 && s1_word_r[31:24] <= 8'd8) begin
              green_pos_nxt  = s1_word_r[23:16];
              green_size_nxt = s1_word_r[27:24];
            end
          end
          bitp_pkg::REL_B_MASK: begin
            if (s1_word_r[15:8] >= 8'd1 && s1_word_r[15:8] <= 8'd8) begin
              blue_pos_nxt  = s1_word_r[7:0];
              blue_size_nxt = s1_word_r[11:8];
            end
            res_valid  = 1'b1;
            res_status = bitp_pkg::ST_FOUND;
          end
          default: ;
        endcase
      end
    end

    if (res_valid) begin
      parse_done_nxt = 1'b1;
    end
  end

  // Result fields are zero unless a framebuffer was found
  always_comb begin
    res_data        = '0;
    res_data.status = res_status;
    if (res_status == bitp_pkg::ST_FOUND) begin
      res_data.fb_address     = address_nxt;
      res_data.line_pitch     = pitch_nxt;
      res_data.screen_width   = width_nxt;
      res_data.screen_height  = height_nxt;
      res_data.pixel_bits     = bpp_nxt[5:0];
      res_data.red_position   = red_pos_nxt;
      res_data.red_size       = red_size_nxt;
      res_data.green_position = green_pos_nxt;
      res_data.green_size     = green_size_nxt;
      res_data.blue_position  = blue_pos_nxt;
      res_data.blue_size      = blue_size_nxt;
    end
  end

  // Walk state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r <= '0;
      block_size_r  <= '0;
      tag_begin_r   <= bitp_pkg::FIRST_TAG;
      tag_type_r    <= '0;
      tag_size_r    <= '0;
      address_r     <= '0;
      pitch_r       <= '0;
      width_r       <= '0;
      height_r      <= '0;
      bpp_r         <= '0;
      ftype_r       <= '0;
      red_pos_r     <= bitp_pkg::RED_POS_DEF;
      red_size_r    <= bitp_pkg::CHAN_SIZE_DEF;
      green_pos_r   <= bitp_pkg::GREEN_POS_DEF;
      green_size_r  <= bitp_pkg::CHAN_SIZE_DEF;
      blue_pos_r    <= bitp_pkg::BLUE_POS_DEF;
      blue_size_r   <= bitp_pkg::CHAN_SIZE_DEF;
      parse_done_r  <= 1'b1;
    end else if (adv) begin
      byte_offset_r <= byte_offset_nxt;
      block_size_r  <= block_size_nxt;
      tag_begin_r   <= tag_begin_nxt;
      tag_type_r    <= tag_type_nxt;
      tag_size_r    <= tag_size_nxt;
      address_r     <= address_nxt;
      pitch_r       <= pitch_nxt;
      width_r       <= width_nxt;
      height_r      <= height_nxt;
      bpp_r         <= bpp_nxt;
      ftype_r       <= ftype_nxt;
      red_pos_r     <= red_pos_nxt;
      red_size_r    <= red_size_nxt;
      green_pos_r   <= green_pos_nxt;
      green_size_r  <= green_size_nxt;
      blue_pos_r    <= blue_pos_nxt;
      blue_size_r   <= blue_size_nxt;
      parse_done_r  <= parse_done_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_data_r.status;
  assign out_ch.fb_address     = out_data_r.fb_address;
  assign out_ch.line_pitch     = out_data_r.line_pitch;
  assign out_ch.screen_width   = out_data_r.screen_width;
  assign out_ch.screen_height  = out_data_r.screen_height;
  assign out_ch.pixel_bits     = out_data_r.pixel_bits;
  assign out_ch.red_position   = out_data_r.red_position;
  assign out_ch.red_size       = out_data_r.red_size;
  assign out_ch.green_position = out_data_r.green_position;
  assign out_ch.green_size     = out_data_r.green_size;
  assign out_ch.blue_position  = out_data_r.blue_position;
  assign out_ch.blue_size      = out_data_r.blue_size;

  // Checks
  a_magic_reported: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_start_r && loader_magic_r != bitp_pkg::MAGIC_VALUE) |=>
      (out_valid_r && out_data_r.status == bitp_pkg::ST_MAGIC))
    else $error("wrong magic not reported on block start");

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !s1_start_r && parse_done_r) |=> !out_valid_r)
    else $error("result produced while idle");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != bitp_pkg::ST_FOUND) |->
      (out_data_r.fb_address == 64'd0 && out_data_r.pixel_bits == 6'd0 &&
       out_data_r.screen_width == 32'd0))
    else $error("failure result carries framebuffer fields");

  a_found_bpp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == bitp_pkg::ST_FOUND) |->
      (out_data_r.pixel_bits == 6'd15 || out_data_r.pixel_bits == 6'd16 ||
       out_data_r.pixel_bits == 6'd24 || out_data_r.pixel_bits == 6'd32))
    else $error("found framebuffer with unsupported depth");

endmodule

`default_nettype wire
